// ===== rtl/core/base64url_stream_encoder_unit_assert.svh =====
// Assertion macros for the encoder top module.
`ifndef BASE64URL_STREAM_ENCODER_UNIT_ASSERT_SVH
`define BASE64URL_STREAM_ENCODER_UNIT_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define B64E_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// Next-cycle implication, checked outside reset.
`define B64E_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

// ===== rtl/core/b64e_pkg.sv =====
package b64e_pkg;

    // How many bits are left over from earlier bytes.
    typedef enum logic [2:0] {
        PH_0 = 3'b001,
        PH_2 = 3'b010,
        PH_4 = 3'b100
    } t_phase;

    // One or two characters produced by one byte.
    typedef struct packed {
        logic [6:0] char0;
        logic [6:0] char1;
        logic       two;
        logic       last;
    } t_pair;

    localparam logic [6:0] ASCII_UPPER_A = 7'h41;
    localparam logic [6:0] ASCII_LOWER_A = 7'h61;
    localparam logic [6:0] ASCII_ZERO    = 7'h30;
    localparam logic [6:0] ASCII_DASH    = 7'h2D;
    localparam logic [6:0] ASCII_UNDER   = 7'h5F;

    // Maps a 6-bit group to its URL-safe alphabet character.
    function automatic logic [6:0] encode_group(input logic [5:0] i_group);
        logic [6:0] v_group;
        logic [6:0] v_char;
        v_group = {1'b0, i_group};
        if (v_group < 7'd26) begin
            v_char = v_group + ASCII_UPPER_A;
        end else if (v_group < 7'd52) begin
            v_char = v_group - 7'd26 + ASCII_LOWER_A;
        end else if (v_group < 7'd62) begin
            v_char = v_group - 7'd52 + ASCII_ZERO;
        end else if (v_group == 7'd62) begin
            v_char = ASCII_DASH;
        end else begin
            v_char = ASCII_UNDER;
        end
        return v_char;
    endfunction

endpackage

// ===== rtl/core/b64e_if.sv =====
interface b64e_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       final_byte;

    modport source (output valid, output data_byte, output final_byte, input ready);
    modport sink (input valid, input data_byte, input final_byte, output ready);
endinterface

interface b64e_out_if;
    logic       valid;
    logic       ready;
    logic [6:0] ascii_char;
    logic       last_char;

    modport source (output valid, output ascii_char, output last_char, input ready);
    modport sink (input valid, input ascii_char, input last_char, output ready);
endinterface

// ===== rtl/core/b64e_pack.sv =====
module b64e_pack (
    input  logic            i_clk,
    input  logic            i_rst_n,
    b64e_in_if.sink         i_byte,
    output logic            o_pair_valid,
    output b64e_pkg::t_pair o_pair,
    input  logic            i_pair_ready
);

    logic             r_iv;
    logic [7:0]       r_byte;
    logic             r_fin;
    b64e_pkg::t_phase r_phase;
    b64e_pkg::t_phase n_phase;
    logic [3:0]       r_lo;
    logic [3:0]       n_lo;
    logic [5:0]       w_g0;
    logic [5:0]       w_g1;
    logic             w_two;
    logic             w_move;

    assign w_move       = r_iv && i_pair_ready;
    assign i_byte.ready = !r_iv || i_pair_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_iv <= 1'b0;
        end else if (i_byte.valid && i_byte.ready) begin
            r_iv <= 1'b1;
        end else if (w_move) begin
            r_iv <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_byte.valid && i_byte.ready) begin
            r_byte <= i_byte.data_byte;
            r_fin  <= i_byte.final_byte;
        end
    end

    // Leftover bits sit right aligned in r_lo; the byte is appended below them.
    always_comb begin
        unique case (r_phase)
            b64e_pkg::PH_2: begin
                w_g0    = {r_lo[1:0], r_byte[7:4]};
                w_g1    = {r_byte[3:0], 2'b00};
                w_two   = r_fin;
                n_phase = r_fin ? b64e_pkg::PH_0 : b64e_pkg::PH_4;
                n_lo    = r_fin ? 4'd0 : r_byte[3:0];
            end
            b64e_pkg::PH_4: begin
                w_g0    = {r_lo, r_byte[7:6]};
                w_g1    = r_byte[5:0];
                w_two   = 1'b1;
                n_phase = b64e_pkg::PH_0;
                n_lo    = 4'd0;
            end
            default: begin
                w_g0    = r_byte[7:2];
                w_g1    = {r_byte[1:0], 4'b0000};
                w_two   = r_fin;
                n_phase = r_fin ? b64e_pkg::PH_0 : b64e_pkg::PH_2;
                n_lo    = r_fin ? 4'd0 : {2'b00, r_byte[1:0]};
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= b64e_pkg::PH_0;
            r_lo    <= 4'd0;
        end else if (w_move) begin
            r_phase <= n_phase;
            r_lo    <= n_lo;
        end
    end

    assign o_pair_valid = r_iv;
    assign o_pair.char0 = b64e_pkg::encode_group(w_g0);
    assign o_pair.char1 = b64e_pkg::encode_group(w_g1);
    assign o_pair.two   = w_two;
    assign o_pair.last  = r_fin;

endmodule

// ===== rtl/core/b64e_ser.sv =====
module b64e_ser (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_pair_valid,
    input  b64e_pkg::t_pair i_pair,
    output logic            o_pair_ready,
    b64e_out_if.source      o_char
);

    logic            r_pv;
    b64e_pkg::t_pair r_pair;
    logic            r_idx;
    logic            w_at_end;
    logic            w_done;

    // The pair is finished when its final character leaves.
    assign w_at_end     = r_idx || !r_pair.two;
    assign w_done       = r_pv && o_char.ready && w_at_end;
    assign o_pair_ready = !r_pv || w_done;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pv  <= 1'b0;
            r_idx <= 1'b0;
        end else if (i_pair_valid && o_pair_ready) begin
            r_pv  <= 1'b1;
            r_idx <= 1'b0;
        end else if (w_done) begin
            r_pv  <= 1'b0;
            r_idx <= 1'b0;
        end else if (r_pv && o_char.ready) begin
            r_idx <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_pair_valid && o_pair_ready) begin
            r_pair <= i_pair;
        end
    end

    assign o_char.valid      = r_pv;
    assign o_char.ascii_char = r_idx ? r_pair.char1 : r_pair.char0;
    assign o_char.last_char  = r_pair.last && w_at_end;

endmodule

// ===== rtl/core/base64url_stream_encoder_unit.sv =====
// Unpadded base64url encoder, one raw byte per input beat.
// i_byte carries data_byte and final_byte; o_char carries one ASCII
// character of the URL-safe alphabet per beat, with last_char set on the
// final character of a message. Both channels use valid/ready.
// A byte yields one character, or two when it completes a 24-bit block or
// is final with leftover bits. Bytes pass an input register, then a pair
// register that the output serializer reads one character per cycle while
// the receiver is ready. The first character of a byte is offered once
// the byte has passed the input register and the pair register; a busy
// pair register can hold it in between. While the receiver is ready, one
// byte per cycle is taken for bytes that give one character; a byte that
// gives two holds the pair register until both leave the single output port.
// Reset (synchronous, active low) empties both registers and clears the
// leftover bits. When the receiver stalls, the current character holds and
// backpressure reaches i_byte once the input register is also full.
`include "base64url_stream_encoder_unit_assert.svh"

module base64url_stream_encoder_unit (
    input  logic       i_clk,
    input  logic       i_rst_n,
    b64e_in_if.sink    i_byte,
    b64e_out_if.source o_char
);

    logic            w_pair_valid;
    logic            w_pair_ready;
    b64e_pkg::t_pair w_pair;

    b64e_pack u_pack (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_byte       (i_byte),
        .o_pair_valid (w_pair_valid),
        .o_pair       (w_pair),
        .i_pair_ready (w_pair_ready)
    );

    b64e_ser u_ser (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_pair_valid (w_pair_valid),
        .i_pair       (w_pair),
        .o_pair_ready (w_pair_ready),
        .o_char       (o_char)
    );

    `B64E_ASSERT_NEXT(a_accept_fills, i_clk, i_rst_n, i_byte.valid && i_byte.ready, w_pair_valid)
    `B64E_ASSERT_NEXT(a_pair_holds, i_clk, i_rst_n, w_pair_valid && !w_pair_ready,
        w_pair_valid && $stable(w_pair))
    `B64E_ASSERT_NOW(a_char_when_pair_busy, i_clk, i_rst_n, !w_pair_ready, o_char.valid)

endmodule

// ===== tb/base64url_stream_encoder_unit_checker.sv =====
module base64url_stream_encoder_unit_checker (
    input  logic i_clk,
    input  logic i_rst_n,
    b64e_in_if   i_byte_ch,
    b64e_out_if  i_char_ch,
    output int   o_fail_count,
    output int   o_chars_pending
);

    // The URL-safe alphabet, first character in the top byte.
    localparam bit [8*64-1:0] URL_SAFE_ALPHABET =
        "ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz0123456789-_";

    typedef struct packed {
        logic [6:0] ascii_char;
        logic       last_char;
    } t_char_beat;

    t_char_beat expected_chars[$];
    logic [3:0] spare_bits;
    int         spare_count;
    int         fail_count = 0;
    int         chars_pending = 0;

    assign o_fail_count    = fail_count;
    assign o_chars_pending = chars_pending;

    function automatic logic [6:0] alphabet_char(input logic [5:0] i_group);
        logic [7:0] v_code;
        v_code = URL_SAFE_ALPHABET[8*(63 - int'(i_group)) +: 8];
        return v_code[6:0];
    endfunction

    // Appends one byte to the spare bits and queues the characters it completes.
    function void encode_byte(input logic [7:0] i_data, input logic i_final);
        logic [11:0] window;
        logic [11:0] shifted;
        logic [11:0] keep_mask;
        int          avail;
        int          produced;
        t_char_beat  beats[2];
        window   = {spare_bits, i_data};
        avail    = spare_count + 8;
        produced = 0;
        while (avail >= 6 && produced < 2) begin
            avail -= 6;
            shifted = window >> avail;
            beats[produced] = '{alphabet_char(shifted[5:0]), 1'b0};
            produced++;
        end
        if (i_final) begin
            // Leftover bits are zero-padded on the right into one more character.
            if (avail > 0 && produced < 2) begin
                shifted = window << (6 - avail);
                beats[produced] = '{alphabet_char(shifted[5:0]), 1'b0};
                produced++;
            end
            beats[produced - 1].last_char = 1'b1;
            spare_bits  = '0;
            spare_count = 0;
        end else begin
            keep_mask   = (12'd1 << avail) - 12'd1;
            shifted     = window & keep_mask;
            spare_bits  = shifted[3:0];
            spare_count = avail;
        end
        for (int k = 0; k < produced; k++) begin
            expected_chars.insert(expected_chars.size(), beats[k]);
        end
    endfunction

    always @(posedge i_clk) begin
        t_char_beat want;
        if (!i_rst_n) begin
            spare_bits  = '0;
            spare_count = 0;
            expected_chars.delete();
        end else begin
            if (i_char_ch.valid === 1'b1 && i_char_ch.ready === 1'b1) begin
                if (expected_chars.size() == 0) begin
                    $error("unexpected character beat: ascii_char %h, last_char %b",
                           i_char_ch.ascii_char, i_char_ch.last_char);
                    fail_count++;
                end else begin
                    want = expected_chars.pop_front();
                    if (i_char_ch.ascii_char !== want.ascii_char) begin
                        $error("ascii_char mismatch: expected %h, actual %h",
                               want.ascii_char, i_char_ch.ascii_char);
                        fail_count++;
                    end
                    if (i_char_ch.last_char !== want.last_char) begin
                        $error("last_char mismatch: expected %b, actual %b",
                               want.last_char, i_char_ch.last_char);
                        fail_count++;
                    end
                end
            end
            if (i_byte_ch.valid === 1'b1 && i_byte_ch.ready === 1'b1) begin
                encode_byte(i_byte_ch.data_byte, i_byte_ch.final_byte);
            end
        end
        chars_pending = expected_chars.size();
    end

endmodule

// ===== tb/base64url_stream_encoder_unit_tb.sv =====
module base64url_stream_encoder_unit_tb;

    localparam int HOLD_OFF_CYCLES = 300;
    localparam int BYTE_TARGET     = 2000;
    localparam int MAX_GAP         = 14;

    logic i_clk = 1'b0;
    logic i_rst_n;
    int   fail_count;
    int   chars_pending;
    bit   tx_idle_on = 1'b1;
    bit   rx_idle_on = 1'b1;
    bit   hold_off_req = 1'b0;

    b64e_in_if  byte_ch ();
    b64e_out_if char_ch ();

    base64url_stream_encoder_unit DUT (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_byte  (byte_ch),
        .o_char  (char_ch)
    );

    base64url_stream_encoder_unit_checker u_checker (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_byte_ch       (byte_ch),
        .i_char_ch       (char_ch),
        .o_fail_count    (fail_count),
        .o_chars_pending (chars_pending)
    );

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    // Called at a falling edge; returns at the falling edge after the beat.
    task automatic send_byte(input logic [7:0] i_data, input logic i_final);
        int gap;
        gap = tx_idle_on ? $urandom_range(0, MAX_GAP) : 0;
        if (gap > 0) begin
            byte_ch.valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        byte_ch.valid      <= 1'b1;
        byte_ch.data_byte  <= i_data;
        byte_ch.final_byte <= i_final;
        @(posedge i_clk);
        while (byte_ch.ready !== 1'b1) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    // The sender goes idle first so that the last beat is not offered again.
    task automatic wait_drained();
        byte_ch.valid <= 1'b0;
        while (chars_pending != 0) @(negedge i_clk);
    endtask

    // Receiver: one draw per character beat, with an occasional long hold-off.
    initial begin
        int stall;
        char_ch.ready = 1'b0;
        forever begin
            @(negedge i_clk);
            forever begin
                stall = hold_off_req ? HOLD_OFF_CYCLES
                                     : (rx_idle_on ? $urandom_range(0, MAX_GAP) : 0);
                hold_off_req = 1'b0;
                if (stall > 0) begin
                    char_ch.ready <= 1'b0;
                    repeat (stall) @(negedge i_clk);
                end
                char_ch.ready <= 1'b1;
                @(posedge i_clk);
                while (char_ch.valid !== 1'b1) @(posedge i_clk);
                @(negedge i_clk);
            end
        end
    end

    initial begin
        int bytes_sent;
        int msg_count;
        int msg_len;
        byte_ch.valid      = 1'b0;
        byte_ch.data_byte  = '0;
        byte_ch.final_byte = 1'b0;
        i_rst_n            = 1'b0;
        repeat (8) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Single-byte messages: final with no spare bits.
        send_byte(8'h00, 1'b1);
        send_byte(8'hFF, 1'b1);
        // Final byte arriving with two spare bits.
        send_byte(8'h80, 1'b0);
        send_byte(8'h01, 1'b1);
        // Full blocks ending on a final byte with four spare bits: "ABCD", "----", "____".
        send_byte(8'h00, 1'b0);
        send_byte(8'h10, 1'b0);
        send_byte(8'h83, 1'b1);
        send_byte(8'hFB, 1'b0);
        send_byte(8'hEF, 1'b0);
        send_byte(8'hBE, 1'b1);
        send_byte(8'hFF, 1'b0);
        send_byte(8'hFF, 1'b0);
        send_byte(8'hFF, 1'b1);
        // Longer messages that wrap past a block boundary.
        send_byte(8'h55, 1'b0);
        send_byte(8'hAA, 1'b0);
        send_byte(8'h0F, 1'b0);
        send_byte(8'hF0, 1'b1);
        send_byte(8'h7F, 1'b0);
        send_byte(8'h80, 1'b0);
        send_byte(8'h01, 1'b0);
        send_byte(8'hFE, 1'b0);
        send_byte(8'h3C, 1'b1);
        wait_drained();

        bytes_sent = 0;
        msg_count  = 0;
        while (bytes_sent < BYTE_TARGET) begin
            msg_len = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40)
                                                  : $urandom_range(1, 6);
            tx_idle_on = ($urandom_range(0, 7) != 0);
            rx_idle_on = ($urandom_range(0, 7) != 0);
            if (msg_count % 90 == 40) begin
                // Sender keeps pushing while the receiver sits still.
                hold_off_req = 1'b1;
                tx_idle_on   = 1'b0;
                msg_len      = 30;
            end
            for (int k = 0; k < msg_len; k++) begin
                send_byte(8'($urandom_range(0, 255)), k == msg_len - 1);
            end
            bytes_sent += msg_len;
            msg_count++;
            if (msg_count % 60 == 0) begin
                wait_drained();
            end
        end

        wait_drained();
        repeat (8) @(negedge i_clk);
        if (fail_count == 0) begin
            $display("base64url_stream_encoder_unit_tb OK");
        end else begin
            $display("base64url_stream_encoder_unit_tb NOT OK");
        end
        $finish;
    end

    initial begin
        #6000000;
        $display("base64url_stream_encoder_unit_tb NOT OK");
        $finish;
    end

endmodule

// ===== files.f =====
+incdir+rtl/core
rtl/core/b64e_pkg.sv
rtl/core/b64e_if.sv
rtl/core/b64e_pack.sv
rtl/core/b64e_ser.sv
rtl/core/base64url_stream_encoder_unit.sv
tb/base64url_stream_encoder_unit_checker.sv
tb/base64url_stream_encoder_unit_tb.sv
